@@ hw/rtl/rdsc_pkg.sv @@
`timescale 1ns / 1ps
package rdsc_pkg;

    localparam int DefCordicSteps = 16;
    localparam int DefMaxHours    = 12;

    localparam logic [0:0] REG_LATITUDE = 1'b0;
    localparam logic [0:0] REG_HOURS    = 1'b1;

    localparam logic [15:0] FULL_TURN  = 16'd36000;
    localparam logic [15:0] HALF_TURN  = 16'd18000;
    localparam logic [15:0] DECAN_W    = 16'd1000;
    localparam logic [15:0] DECAN_MID  = 16'd500;
    localparam logic [5:0]  DECANS     = 6'd36;
    localparam logic [15:0] ZERO_ASC   = 16'd9000;
    localparam logic signed [14:0] LAT_LIMIT = 15'sd8900;

    localparam logic signed [33:0] U90  = 34'sd589824000;
    localparam logic signed [33:0] U180 = 34'sd1179648000;
    localparam logic signed [33:0] U360 = 34'sd2359296000;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam longint OBLIQ_UNITS = 64'sd153611796;
    // ceil(2^30 / 1000): exact floor division for values below 36000
    localparam logic [20:0] DECAN_RECIP = 21'd1073742;

    typedef struct packed {
        logic        valid;
        logic [15:0] lst;
        logic [3:0]  cnt;
        logic        flip;
    } rot_side_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] lst;
        logic [3:0]  cnt;
        logic        zero;
    } vec_side_t;

    typedef struct packed {
        logic [15:0] lst;
        logic [5:0]  first;
        logic [15:0] asc;
        logic [3:0]  cnt;
    } hour_item_t;

    function automatic logic signed [33:0] atan_unit(input int i);
        logic signed [33:0] r;
        case (i)
            0:  r = 34'sd294912000;
            1:  r = 34'sd174096719;
            2:  r = 34'sd91987925;
            3:  r = 34'sd46694507;
            4:  r = 34'sd23437865;
            5:  r = 34'sd11730358;
            6:  r = 34'sd5866610;
            7:  r = 34'sd2933484;
            8:  r = 34'sd1466764;
            9:  r = 34'sd733385;
            10: r = 34'sd366693;
            11: r = 34'sd183346;
            12: r = 34'sd91673;
            13: r = 34'sd45837;
            14: r = 34'sd22918;
            15: r = 34'sd11459;
            16: r = 34'sd5730;
            17: r = 34'sd2865;
            18: r = 34'sd1432;
            19: r = 34'sd716;
            20: r = 34'sd358;
            21: r = 34'sd179;
            22: r = 34'sd90;
            23: r = 34'sd45;
            default: r = '0;
        endcase
        return r;
    endfunction

    // obliquity cos/sin, evaluated at elaboration
    function automatic longint obliq_rot(input int steps, input bit want_sin);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(GAIN_Q30);
        y = 0;
        z = OBLIQ_UNITS;
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_unit(i));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_unit(i));
            end
        end
        return want_sin ? y : x;
    endfunction

endpackage

@@ hw/rtl/rdsc_rot_cell.sv @@
`timescale 1ns / 1ps
module rdsc_rot_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic signed [33:0] z_out
);
    import rdsc_pkg::*;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [31:0] dx, dy;

    always_comb begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (z_in >= 0) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan_unit(STEP);
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan_unit(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

@@ hw/rtl/rdsc_vec_cell.sv @@
`timescale 1ns / 1ps
module rdsc_vec_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [35:0] x_in,
    input  logic signed [35:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [35:0] x_out,
    output logic signed [35:0] y_out,
    output logic signed [33:0] z_out
);
    import rdsc_pkg::*;

    logic signed [35:0] x_reg, x_next;
    logic signed [35:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [35:0] dx, dy;

    always_comb begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (y_in > 0) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan_unit(STEP);
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan_unit(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

@@ hw/rtl/rdsc_hours.sv @@
`timescale 1ns / 1ps
module rdsc_hours (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  rdsc_pkg::hour_item_t item,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_hour_number,
    output logic [5:0]           m_decan_num,
    output logic [15:0]          m_star_offset,
    output logic                 m_visible,
    output logic [15:0]          m_ascendant_angle,
    output logic                 m_last_hour
);
    import rdsc_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  i_reg, i_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] hl_reg, hl_next;
    logic [5:0]  dec_reg, dec_next;
    logic [15:0] asc_reg, asc_next;
    logic        mv_reg, mv_next;

    logic [3:0]  o_hour_reg;
    logic [5:0]  o_dec_reg;
    logic [15:0] o_ha_reg;
    logic        o_vis_reg;
    logic [15:0] o_asc_reg;
    logic        o_last_reg;

    logic        load_out, last, take;
    logic [15:0] star;
    logic [16:0] ha_w;
    logic [15:0] ha;
    logic [16:0] hl_inc;
    logic [6:0]  dec_inc;

    always_comb begin
        load_out = busy_reg && (!mv_reg || m_ready);
        last     = (i_reg + 4'd1) == cnt_reg;
        free     = !busy_reg || (load_out && last);
        take     = item_valid && free;

        star = 16'(dec_reg * DECAN_W) + DECAN_MID;
        if (hl_reg >= star) ha_w = {1'b0, hl_reg} - {1'b0, star};
        else ha_w = {1'b0, hl_reg} + {1'b0, FULL_TURN} - {1'b0, star};
        ha = ha_w[15:0];

        hl_inc  = {1'b0, hl_reg} + {1'b0, DECAN_W};
        dec_inc = {1'b0, dec_reg} + 7'd1;

        busy_next = busy_reg;
        i_next    = i_reg;
        cnt_next  = cnt_reg;
        hl_next   = hl_reg;
        dec_next  = dec_reg;
        asc_next  = asc_reg;
        if (load_out) begin
            busy_next = !last;
            i_next    = i_reg + 4'd1;
            hl_next   = (hl_inc >= {1'b0, FULL_TURN}) ? 16'(hl_inc - {1'b0, FULL_TURN})
                                                      : hl_inc[15:0];
            dec_next  = (dec_inc >= {1'b0, DECANS}) ? 6'(dec_inc - {1'b0, DECANS})
                                                    : dec_inc[5:0];
        end
        if (take) begin
            busy_next = item.cnt != 4'd0;
            i_next    = 4'd0;
            cnt_next  = item.cnt;
            hl_next   = item.lst;
            dec_next  = item.first;
            asc_next  = item.asc;
        end

        if (load_out) mv_next = 1'b1;
        else if (m_ready) mv_next = 1'b0;
        else mv_next = mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg   <= i_next;
        cnt_reg <= cnt_next;
        hl_reg  <= hl_next;
        dec_reg <= dec_next;
        asc_reg <= asc_next;
        if (load_out) begin
            o_hour_reg <= i_reg;
            o_dec_reg  <= dec_reg;
            o_ha_reg   <= ha;
            o_vis_reg  <= ha < HALF_TURN;
            o_asc_reg  <= asc_reg;
            o_last_reg <= last;
        end
    end

    assign m_valid           = mv_reg;
    assign m_hour_number     = o_hour_reg;
    assign m_decan_num       = o_dec_reg;
    assign m_star_offset     = o_ha_reg;
    assign m_visible         = o_vis_reg;
    assign m_ascendant_angle = o_asc_reg;
    assign m_last_hour       = o_last_reg;
endmodule

@@ hw/rtl/rising_decan_star_clock.sv @@
`timescale 1ns / 1ps
// Throughput: one result per cycle while m_ready is high; a request yields
// min(hours, MAX_HOURS) results, none for zero hours, set by the hour emitter,
// which takes the next request as the last result of the current one leaves. All
// three CORDIC chains advance one cell a cycle while the pipeline is not stalled.
// Reset (aresetn low, synchronous): pipeline and output empty, latitude 30.00 deg,
// 12 hours per night.
module rising_decan_star_clock #(
    parameter int CORDIC_STEPS = rdsc_pkg::DefCordicSteps,
    parameter int MAX_HOURS    = rdsc_pkg::DefMaxHours
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_sidereal_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_hour_number,
    output logic [5:0]  m_decan_num,
    output logic [15:0] m_star_offset,
    output logic        m_visible,
    output logic [15:0] m_ascendant_angle,
    output logic        m_last_hour
);
    import rdsc_pkg::*;

    localparam int N = CORDIC_STEPS;
    localparam logic [3:0] MaxHoursC = 4'(MAX_HOURS);
    localparam logic signed [31:0] CosE = 32'(obliq_rot(CORDIC_STEPS, 1'b0));
    localparam logic signed [31:0] SinE = 32'(obliq_rot(CORDIC_STEPS, 1'b1));

    // configuration
    logic signed [14:0] lat_reg;
    logic [3:0]         hours_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg   <= 15'sd3000;
            hours_reg <= 4'd12;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_LATITUDE: lat_reg   <= $signed(pwdata[14:0]);
                REG_HOURS:    hours_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LATITUDE: prdata = {{17{lat_reg[14]}}, lat_reg};
            REG_HOURS:    prdata = {28'd0, hours_reg};
            default:      prdata = '0;
        endcase
    end

    logic adv, f2_valid, emit_free;
    assign adv     = !f2_valid || emit_free;
    assign s_ready = adv;

    // stage 0: range reduction
    logic [15:0]        lst_in;
    logic signed [14:0] lat_sat;
    logic signed [33:0] a_raw, a_l;
    logic               flip_in;
    logic signed [33:0] zl0_reg, zp0_reg;
    rot_side_t          rside [0:N];

    always_comb begin
        lst_in = (s_sidereal_angle >= FULL_TURN) ? s_sidereal_angle - FULL_TURN
                                                 : s_sidereal_angle;
        if (lat_reg > LAT_LIMIT) lat_sat = LAT_LIMIT;
        else if (lat_reg < -LAT_LIMIT) lat_sat = -LAT_LIMIT;
        else lat_sat = lat_reg;
        a_raw = $signed({2'b00, lst_in, 16'd0});
        if (a_raw > U180) a_raw = a_raw - U360;
        flip_in = 1'b0;
        a_l = a_raw;
        if (a_raw > U90) begin
            a_l = a_raw - U180;
            flip_in = 1'b1;
        end else if (a_raw < -U90) begin
            a_l = a_raw + U180;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rside[0] <= '0;
        end else if (adv) begin
            rside[0].valid <= s_valid;
            rside[0].lst   <= lst_in;
            rside[0].cnt   <= (hours_reg > MaxHoursC) ? MaxHoursC : hours_reg;
            rside[0].flip  <= flip_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zl0_reg <= a_l;
            zp0_reg <= {{3{lat_sat[14]}}, lat_sat, 16'd0};
        end
    end

    // rotation chains: sidereal lane and latitude lane
    logic signed [31:0] lx [0:N];
    logic signed [31:0] ly [0:N];
    logic signed [33:0] lz [0:N];
    logic signed [31:0] px [0:N];
    logic signed [31:0] py [0:N];
    logic signed [33:0] pz [0:N];

    assign lx[0] = GAIN_Q30;
    assign ly[0] = '0;
    assign lz[0] = zl0_reg;
    assign px[0] = GAIN_Q30;
    assign py[0] = '0;
    assign pz[0] = zp0_reg;

    for (genvar k = 0; k < N; k++) begin : g_rot
        rdsc_rot_cell #(.STEP(k)) u_lcell (
            .aclk(aclk), .en(adv),
            .x_in(lx[k]), .y_in(ly[k]), .z_in(lz[k]),
            .x_out(lx[k+1]), .y_out(ly[k+1]), .z_out(lz[k+1])
        );
        rdsc_rot_cell #(.STEP(k)) u_pcell (
            .aclk(aclk), .en(adv),
            .x_in(px[k]), .y_in(py[k]), .z_in(pz[k]),
            .x_out(px[k+1]), .y_out(py[k+1]), .z_out(pz[k+1])
        );
        always_ff @(posedge aclk) begin
            if (!aresetn) rside[k+1] <= '0;
            else if (adv) rside[k+1] <= rside[k];
        end
    end

    // products
    logic signed [31:0] cl, sl;
    logic signed [63:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [31:0] cp1_reg;
    logic signed [63:0] p1s, p4s;
    logic signed [32:0] n2_reg, q3_reg;
    logic signed [35:0] num_reg, den_reg;
    logic signed [63:0] den_w;
    rot_side_t          m1_side, m2_side, m3_side;

    assign cl   = rside[N].flip ? -lx[N] : lx[N];
    assign sl   = rside[N].flip ? -ly[N] : ly[N];
    assign p1s  = p1_reg >>> 30;
    assign p4s  = p4_reg >>> 30;
    assign den_w = -(p4s + 64'(q3_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_side <= '0;
            m2_side <= '0;
            m3_side <= '0;
        end else if (adv) begin
            m1_side <= rside[N];
            m2_side <= m1_side;
            m3_side <= m2_side;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg  <= sl * CosE;
            p2_reg  <= cl * px[N];
            p3_reg  <= py[N] * SinE;
            cp1_reg <= px[N];
            p4_reg  <= $signed(p1s[31:0]) * cp1_reg;
            n2_reg  <= 33'(p2_reg >>> 30);
            q3_reg  <= 33'(p3_reg >>> 30);
            num_reg <= 36'(n2_reg);
            den_reg <= den_w[35:0];
        end
    end

    // vectoring chain
    logic signed [35:0] vx [0:N];
    logic signed [35:0] vy [0:N];
    logic signed [33:0] vz [0:N];
    vec_side_t          vside [0:N];

    always_comb begin
        vside[0].valid = m3_side.valid;
        vside[0].lst   = m3_side.lst;
        vside[0].cnt   = m3_side.cnt;
        vside[0].zero  = (num_reg == 0) && (den_reg == 0);
        if (den_reg < 0) begin
            vx[0] = -den_reg;
            vy[0] = -num_reg;
            vz[0] = U180;
        end else begin
            vx[0] = den_reg;
            vy[0] = num_reg;
            vz[0] = '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_vec
        rdsc_vec_cell #(.STEP(k)) u_vcell (
            .aclk(aclk), .en(adv),
            .x_in(vx[k]), .y_in(vy[k]), .z_in(vz[k]),
            .x_out(vx[k+1]), .y_out(vy[k+1]), .z_out(vz[k+1])
        );
        always_ff @(posedge aclk) begin
            if (!aresetn) vside[k+1] <= '0;
            else if (adv) vside[k+1] <= vside[k];
        end
    end

    // angle rounding, then decan
    logic signed [33:0] zred, zrnd;
    logic [17:0]        rnd;
    logic [15:0]        asc_w;
    logic [15:0]        f1_asc_reg;
    vec_side_t          f1_side;
    logic [36:0]        dprod;
    hour_item_t         f2_item_reg;

    always_comb begin
        if (vz[N] < 0) zred = vz[N] + U360;
        else if (vz[N] >= U360) zred = vz[N] - U360;
        else zred = vz[N];
        zrnd = (zred + 34'sd32768) >>> 16;
        rnd  = zrnd[17:0];
        if (vside[N].zero) asc_w = ZERO_ASC;
        else if (rnd >= {2'b00, FULL_TURN}) asc_w = '0;
        else asc_w = rnd[15:0];
        dprod = f1_asc_reg * DECAN_RECIP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_side  <= '0;
            f2_valid <= 1'b0;
        end else if (adv) begin
            f1_side  <= vside[N];
            f2_valid <= f1_side.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_asc_reg        <= asc_w;
            f2_item_reg.lst   <= f1_side.lst;
            f2_item_reg.cnt   <= f1_side.cnt;
            f2_item_reg.asc   <= f1_asc_reg;
            f2_item_reg.first <= dprod[35:30];
        end
    end

    rdsc_hours u_hours (
        .aclk(aclk), .aresetn(aresetn),
        .item_valid(f2_valid), .item(f2_item_reg), .free(emit_free),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hour_number(m_hour_number), .m_decan_num(m_decan_num),
        .m_star_offset(m_star_offset), .m_visible(m_visible),
        .m_ascendant_angle(m_ascendant_angle), .m_last_hour(m_last_hour)
    );

`ifndef SYNTHESIS
    a_vis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_visible == (m_star_offset < HALF_TURN)))
        else $error("visibility flag disagrees with hour angle");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_decan_num < DECANS && m_star_offset < FULL_TURN
                     && m_ascendant_angle < FULL_TURN))
        else $error("result field out of range");
    a_hours: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour_number < MaxHoursC))
        else $error("hour number beyond limit");
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_hour) ##1 m_valid |->
            m_hour_number == $past(m_hour_number) + 4'd1)
        else $error("hour sequence broken");
`endif
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import rdsc_pkg::*;

    typedef struct packed {
        logic [3:0]  hour;
        logic [5:0]  decan;
        logic [15:0] hour_ang;
        logic        vis;
        logic [15:0] asc;
        logic        last;
    } night_hour_t;

    localparam int  STEPS     = 16;
    localparam int  HOUR_CAP  = 12;
    localparam int  DRAIN_CYC = 2 * STEPS + 30;
    localparam logic [2:0] ADDR_LAT   = {REG_LATITUDE, 2'b00};
    localparam logic [2:0] ADDR_HOURS = {REG_HOURS, 2'b00};

    localparam longint ATAN_TBL [STEPS] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_sidereal_angle = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_hour_number;
    logic [5:0]  m_decan_num;
    logic [15:0] m_star_offset;
    logic        m_visible;
    logic [15:0] m_ascendant_angle;
    logic        m_last_hour;

    night_hour_t  hour_results_q[$];
    logic signed [14:0] lat_shadow = 15'sd3000;
    logic [3:0]   hours_shadow = 4'd12;
    bit           calm = 1'b0;
    int           errors = 0;
    int           requests_sent = 0;
    int           hours_checked = 0;

    rising_decan_star_clock u_dut (.*);

    always #4 aclk = ~aclk;

    always @(negedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 29);

    // result checker
    always @(posedge aclk) begin
        night_hour_t e;
        if (aresetn && m_valid && m_ready) begin
            if (hour_results_q.size() == 0) begin
                $error("unexpected result hour=%0d", m_hour_number);
                errors++;
            end else begin
                e = hour_results_q.pop_front();
                hours_checked++;
                if (m_hour_number !== e.hour) begin
                    $error("hour_number exp %0d got %0d", e.hour, m_hour_number);
                    errors++;
                end
                if (m_decan_num !== e.decan) begin
                    $error("decan_num exp %0d got %0d", e.decan, m_decan_num);
                    errors++;
                end
                if (m_star_offset !== e.hour_ang) begin
                    $error("star_offset exp %0d got %0d", e.hour_ang, m_star_offset);
                    errors++;
                end
                if (m_visible !== e.vis) begin
                    $error("visible exp %0d got %0d", e.vis, m_visible);
                    errors++;
                end
                if (m_ascendant_angle !== e.asc) begin
                    $error("ascendant_angle exp %0d got %0d", e.asc, m_ascendant_angle);
                    errors++;
                end
                if (m_last_hour !== e.last) begin
                    $error("last_hour exp %0d got %0d", e.last, m_last_hour);
                    errors++;
                end
            end
        end
    end

    // cos/sin in Q30 of an angle in 1/65536 hundredths
    function automatic void cordic_rotate(input longint a, output longint c,
                                          output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (a < 0) a += U360;
        if (a > U180) a -= U360;
        if (a > U90) begin
            a -= U180;
            flip = 1;
        end else if (a < -U90) begin
            a += U180;
            flip = 1;
        end
        z = a;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic int unsigned cordic_atan2(input longint y, input longint x);
        longint z, dx, dy, r;
        if (x == 0 && y == 0) return 9000;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = U180;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        while (z < 0) z += U360;
        while (z >= U360) z -= U360;
        r = (z + 32768) >>> 16;
        if (r >= 36000) r = 0;
        return int'(r);
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    task automatic predict_night_hours(input logic [15:0] angle);
        int unsigned lst, asc, first, cnt, dec, hl, star, ha;
        int lat;
        longint cl, sl, cp, sp, ce, se, num, den;
        night_hour_t e;
        lst = angle % 36000;
        lat = lat_shadow;
        if (lat > 8900) lat = 8900;
        if (lat < -8900) lat = -8900;
        cordic_rotate(longint'(lst) * 65536, cl, sl);
        cordic_rotate(longint'(lat) * 65536, cp, sp);
        cordic_rotate(OBLIQ_UNITS, ce, se);
        num = q30_mul(cl, cp);
        den = -(q30_mul(q30_mul(sl, ce), cp) + q30_mul(sp, se));
        asc = cordic_atan2(num, den);
        first = asc / 1000;
        if (first >= 36) first = 35;
        cnt = (hours_shadow > HOUR_CAP) ? HOUR_CAP : hours_shadow;
        for (int unsigned i = 0; i < cnt; i++) begin
            dec = (first + i) % 36;
            hl = (lst + i * 1000) % 36000;
            star = dec * 1000 + 500;
            ha = (hl + 36000 - star) % 36000;
            e.hour = 4'(i);
            e.decan = 6'(dec);
            e.hour_ang = 16'(ha);
            e.vis = (ha < 18000);
            e.asc = 16'(asc);
            e.last = (i + 1 == cnt);
            hour_results_q.push_back(e);
        end
    endtask

    // one request; s_valid stays up when the next request follows directly
    task automatic send_angle(input logic [15:0] angle);
        @(negedge aclk);
        if (!calm) begin
            while ($urandom_range(99) < 29) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_sidereal_angle <= angle;
        predict_night_hours(angle);
        requests_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (hour_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input int value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LAT) lat_shadow = value[14:0];
        else hours_shadow = value[3:0];
    endtask

    task automatic set_night(input int lat, input int hours);
        wait_idle();
        apb_write(ADDR_LAT, lat);
        apb_write(ADDR_HOURS, hours);
    endtask

    task automatic test_angle_extremes();
        logic [15:0] pts[8] = '{16'd0, 16'd35999, 16'd36000, 16'd65535,
                                16'd9000, 16'd27000, 16'd18000, 16'hAAAA};
        foreach (pts[i]) send_angle(pts[i]);
    endtask

    task automatic test_latitude_extremes();
        // saturated, limit and equator latitudes at the 90 and 270 deg angles
        int lats[5] = '{8900, -8900, 16383, -16384, 0};
        foreach (lats[i]) begin
            set_night(lats[i], 3);
            send_angle(16'd9000);
            send_angle(16'd27000);
        end
    endtask

    task automatic test_hour_counts();
        int counts[5] = '{0, 1, 15, 13, 12};
        foreach (counts[i]) begin
            set_night(-2500, counts[i]);
            send_angle(16'($urandom_range(35999)));
        end
    endtask

    task automatic test_random_nights();
        for (int ph = 0; ph < 5; ph++) begin
            set_night($urandom_range(1, 0) ? int'($urandom_range(17800)) - 8900
                                           : int'($urandom_range(32767)) - 16384,
                      $urandom_range(1, 15));
            calm = (ph == 2);
            for (int k = 0; k < 28; k++)
                send_angle($urandom_range(9, 0) == 0 ? 16'($urandom)
                                                     : 16'($urandom_range(35999)));
        end
        calm = 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("rising_decan_star_clock test failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_angle_extremes();
        test_latitude_extremes();
        test_hour_counts();
        test_random_nights();
        wait_idle();
        $display("covered %0d requests, %0d hour results checked", requests_sent,
                 hours_checked);
        $display("latitudes incl. saturation, hour counts 0..15, full angle range");
        if (errors == 0)
            $display("rising_decan_star_clock test passed");
        else
            $display("rising_decan_star_clock test failed");
        $finish;
    end

endmodule
